@@ design/cssm_pkg.sv @@
// ----------------------------------------------------------------------------
// cssm_pkg
// Shared types and constants of the contact safety state machine: state
// codes, controller states, register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package cssm_pkg;

  // Width of the time registers as seen on the configuration port.
  localparam int CFG_TIME_W = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int ANGLE_LIM_W = 15;
  localparam int Q15_W = 16;
  localparam int ELAPSED_W = 24;

  // Recovery ramp fraction: quotient bits of 16384 * t / ramp with t < ramp.
  localparam int DIV_STEPS = 14;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [Q15_W-1:0] Q15_ONE  = 16'h8000;
  localparam logic [Q15_W-1:0] Q15_HALF = 16'h4000;
  localparam logic [Q15_W-1:0] Q15_ZERO = 16'h0000;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_GRACE_TIME    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOSS_DEBOUNCE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REC_DEBOUNCE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REC_RAMP      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ROLL      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PITCH     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SINGLE_SCALE  = 3'd6;

  typedef enum logic [2:0] {
    ST_AIR      = 3'd0,
    ST_FIRST    = 3'd1,
    ST_SECOND   = 3'd2,
    ST_DUAL     = 3'd3,
    ST_RECOVERY = 3'd4
  } safety_state_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_STEP_A,
    FSM_STEP_B,
    FSM_DIV,
    FSM_LOAD
  } cssm_fsm_t;

  typedef struct packed {
    logic capture;
    logic step_a;
    logic step_b;
    logic div_step;
    logic load;
  } cssm_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic out_busy;
  } cssm_status_t;

endpackage

@@ design/cssm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cssm_ctrl
// Sequencer of the contact safety state machine: accepts an item, walks the
// datapath through its update steps and the ramp divider, and loads the
// output register once it is free.
// ----------------------------------------------------------------------------
module cssm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  cssm_pkg::cssm_status_t status,
  output cssm_pkg::cssm_cmd_t    cmd
);
  import cssm_pkg::*;

  cssm_fsm_t              fsm_r, fsm_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r     <= FSM_IDLE;
      div_cnt_r <= '0;
    end else begin
      fsm_r     <= fsm_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // Next state.
  always_comb begin
    fsm_nxt     = fsm_r;
    div_cnt_nxt = div_cnt_r;
    case (fsm_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          fsm_nxt = FSM_STEP_A;
        end
      end
      FSM_STEP_A: begin
        fsm_nxt = FSM_STEP_B;
      end
      FSM_STEP_B: begin
        fsm_nxt     = FSM_DIV;
        div_cnt_nxt = '0;
      end
      FSM_DIV: begin
        if (!status.div_needed || div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          fsm_nxt = FSM_LOAD;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      FSM_LOAD: begin
        if (!status.out_busy) begin
          fsm_nxt = FSM_IDLE;
        end
      end
      default: begin
        fsm_nxt = FSM_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (fsm_r)
      FSM_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      FSM_STEP_A: begin
        cmd.step_a = 1'b1;
      end
      FSM_STEP_B: begin
        cmd.step_b = 1'b1;
      end
      FSM_DIV: begin
        cmd.div_step = status.div_needed;
      end
      FSM_LOAD: begin
        cmd.load = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/cssm_dp.sv @@
// ----------------------------------------------------------------------------
// cssm_dp
// Datapath of the contact safety state machine: configuration registers,
// grace and debounce timers, state register, serial ramp divider and the
// output register.
// ----------------------------------------------------------------------------
module cssm_dp #(
  parameter int TIME_BITS  = 24,
  parameter int ANGLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cssm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cssm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [1:0]                        grounded_mask,
  input  logic signed [15:0]                roll_angle,
  input  logic signed [15:0]                pitch_angle,
  input  logic [15:0]                       tick_us,
  input  cssm_pkg::cssm_cmd_t               cmd,
  output cssm_pkg::cssm_status_t            status,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [2:0]                        safety_state,
  output logic                              state_switched,
  output logic                              one_wheel_support,
  output logic                              airborne,
  output logic [cssm_pkg::Q15_W-1:0]        authority,
  output logic [cssm_pkg::ELAPSED_W-1:0]    elapsed_in_state_us,
  output logic [1:0]                        effective_grounded_mask
);
  import cssm_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
  localparam int MAG_W = (ANGLE_BITS > ANGLE_LIM_W) ? ANGLE_BITS : ANGLE_LIM_W;
  localparam int EXT_W = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Configuration registers.
  logic [CFG_TIME_W-1:0]  grace_time_r, loss_deb_r, rec_deb_r, ramp_r;
  logic [ANGLE_LIM_W-1:0] max_roll_r, max_pitch_r;
  logic [Q15_W-1:0]       scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grace_time_r <= 24'd50000;
      loss_deb_r   <= 24'd20000;
      rec_deb_r    <= 24'd50000;
      ramp_r       <= 24'd300000;
      max_roll_r   <= 15'd1434;
      max_pitch_r  <= 15'd1434;
      scale_r      <= 16'd19661;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRACE_TIME:    grace_time_r <= cfg_wdata;
        REG_LOSS_DEBOUNCE: loss_deb_r   <= cfg_wdata;
        REG_REC_DEBOUNCE:  rec_deb_r    <= cfg_wdata;
        REG_REC_RAMP:      ramp_r       <= cfg_wdata;
        REG_MAX_ROLL:      max_roll_r   <= cfg_wdata[ANGLE_LIM_W-1:0];
        REG_MAX_PITCH:     max_pitch_r  <= cfg_wdata[ANGLE_LIM_W-1:0];
        REG_SINGLE_SCALE:  scale_r      <= cfg_wdata[Q15_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [1:0]        mask_r;
  logic signed [15:0] roll_r, pitch_r;
  logic [15:0]       tick_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mask_r  <= grounded_mask;
      roll_r  <= roll_angle;
      pitch_r <= pitch_angle;
      tick_r  <= tick_us;
    end
  end

  // Block state.
  logic [TIME_BITS-1:0] grace_first_r, grace_second_r, state_time_r, cand_time_r;
  logic [TIME_BITS-1:0] st_sum_r;
  safety_state_t        cur_state_r, cand_state_r, prev_state_r;
  safety_state_t        requested_r, observed_r;
  logic                 roll_ok_r, pitch_ok_r;

  // Step A: grace timers, request mapping, candidate and time sums, angle limit checks.
  logic [TIME_BITS-1:0] tick_ext, grace_load, grace_first_nxt, grace_second_nxt;
  logic [TIME_BITS:0]   st_add, cand_add;
  logic [TIME_BITS-1:0] st_sat, cand_sat;
  safety_state_t        observed, requested;
  logic [EXT_W-1:0]     roll_ext, pitch_ext;
  logic [ANGLE_BITS-1:0] roll_v, pitch_v, roll_mag, pitch_mag;

  always_comb begin
    tick_ext   = TIME_BITS'(tick_r);
    grace_load = (CMP_W'(grace_time_r) > CMP_W'(TIME_MAX)) ? TIME_MAX
                                                            : TIME_BITS'(grace_time_r);
    grace_first_nxt  = mask_r[0] ? grace_load :
                       (grace_first_r > tick_ext) ? grace_first_r - tick_ext : '0;
    grace_second_nxt = mask_r[1] ? grace_load :
                       (grace_second_r > tick_ext) ? grace_second_r - tick_ext : '0;

    st_add   = {1'b0, state_time_r} + {1'b0, tick_ext};
    cand_add = {1'b0, cand_time_r} + {1'b0, tick_ext};
    st_sat   = st_add[TIME_BITS] ? TIME_MAX : st_add[TIME_BITS-1:0];
    cand_sat = cand_add[TIME_BITS] ? TIME_MAX : cand_add[TIME_BITS-1:0];

    case (mask_r)
      2'b11:   observed = ST_DUAL;
      2'b01:   observed = ST_FIRST;
      2'b10:   observed = ST_SECOND;
      default: observed = ST_AIR;
    endcase
    requested = (observed == ST_DUAL && cur_state_r != ST_DUAL) ? ST_RECOVERY : observed;

    // Magnitudes over the low ANGLE_BITS of the sign-extended angles; the most
    // negative code keeps its own pattern, read as unsigned.
    roll_ext  = EXT_W'(roll_r);
    pitch_ext = EXT_W'(pitch_r);
    roll_v    = roll_ext[ANGLE_BITS-1:0];
    pitch_v   = pitch_ext[ANGLE_BITS-1:0];
    roll_mag  = roll_v[ANGLE_BITS-1] ? (~roll_v + 1'b1) : roll_v;
    pitch_mag = pitch_v[ANGLE_BITS-1] ? (~pitch_v + 1'b1) : pitch_v;
  end

  // Step B: debounce decision, recovery exit and divider start.
  logic [CFG_TIME_W-1:0] deb;
  logic                  switch_req, st_ge, ramp_zero, st1_ge, exit_rec;
  safety_state_t         cur1;
  logic [TIME_BITS-1:0]  st1;
  logic [CMP_W-1:0]      st1_ext;

  always_comb begin
    deb        = (requested_r == ST_RECOVERY) ? rec_deb_r : loss_deb_r;
    switch_req = (requested_r != cur_state_r) && (CMP_W'(cand_time_r) >= CMP_W'(deb));
    st_ge      = CMP_W'(st_sum_r) >= CMP_W'(ramp_r);
    ramp_zero  = (ramp_r == '0);
    cur1       = switch_req ? requested_r : cur_state_r;
    st1        = switch_req ? '0 : st_sum_r;
    st1_ge     = switch_req ? ramp_zero : st_ge;
    exit_rec   = (cur1 == ST_RECOVERY) && (observed_r == ST_DUAL) && st1_ge &&
                 roll_ok_r && pitch_ok_r;
    st1_ext    = CMP_W'(st1);
  end

  // Ramp divider: restoring division, one quotient bit a step.
  logic [CFG_TIME_W-1:0] rem_r;
  logic [DIV_STEPS-1:0]  quot_r;
  logic                  div_needed_r;
  logic [CFG_TIME_W:0]   rem_shift, rem_diff;
  logic                  rem_ge;

  always_comb begin
    rem_shift = {rem_r, 1'b0};
    rem_ge    = rem_shift >= {1'b0, ramp_r};
    rem_diff  = rem_shift - {1'b0, ramp_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grace_first_r  <= '0;
      grace_second_r <= '0;
      state_time_r   <= '0;
      cand_time_r    <= '0;
      cur_state_r    <= ST_AIR;
      cand_state_r   <= ST_AIR;
      prev_state_r   <= ST_AIR;
      div_needed_r   <= 1'b0;
    end else begin
      if (cmd.step_a) begin
        grace_first_r  <= grace_first_nxt;
        grace_second_r <= grace_second_nxt;
        prev_state_r   <= cur_state_r;
        if (requested != cand_state_r) begin
          cand_state_r <= requested;
          cand_time_r  <= '0;
        end else begin
          cand_time_r  <= cand_sat;
        end
      end
      if (cmd.step_b) begin
        if (exit_rec) begin
          cur_state_r  <= ST_DUAL;
          cand_state_r <= ST_DUAL;
          state_time_r <= '0;
          cand_time_r  <= '0;
        end else begin
          cur_state_r  <= cur1;
          state_time_r <= st1;
        end
        div_needed_r <= (cur1 == ST_RECOVERY) && !exit_rec && !st1_ge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_a) begin
      st_sum_r    <= st_sat;
      requested_r <= requested;
      observed_r  <= observed;
      roll_ok_r   <= MAG_W'(roll_mag) <= MAG_W'(max_roll_r);
      pitch_ok_r  <= MAG_W'(pitch_mag) <= MAG_W'(max_pitch_r);
    end
    if (cmd.step_b) begin
      // Only meaningful when the time is below the ramp, so it fits the ramp width.
      rem_r  <= st1_ext[CFG_TIME_W-1:0];
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_diff[CFG_TIME_W-1:0] : rem_shift[CFG_TIME_W-1:0];
      quot_r <= {quot_r[DIV_STEPS-2:0], rem_ge};
    end
  end

  // Output register.
  logic [Q15_W-1:0] auth_nxt;
  logic [CMP_W-1:0] st_out_ext;
  logic             out_tvalid_r;

  always_comb begin
    case (cur_state_r)
      ST_AIR:              auth_nxt = Q15_ZERO;
      ST_FIRST, ST_SECOND: auth_nxt = (scale_r > Q15_ONE) ? Q15_ONE : scale_r;
      ST_RECOVERY:         auth_nxt = div_needed_r ? (Q15_HALF + Q15_W'(quot_r)) : Q15_ONE;
      default:             auth_nxt = Q15_ONE;
    endcase
    st_out_ext = CMP_W'(state_time_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      safety_state            <= cur_state_r;
      state_switched          <= (cur_state_r != prev_state_r);
      one_wheel_support       <= (cur_state_r == ST_FIRST) || (cur_state_r == ST_SECOND);
      airborne                <= (cur_state_r == ST_AIR);
      authority               <= auth_nxt;
      elapsed_in_state_us     <= st_out_ext[ELAPSED_W-1:0];
      effective_grounded_mask <= {grace_second_r != '0, grace_first_r != '0};
    end
  end

  assign out_tvalid        = out_tvalid_r;
  assign status.out_busy   = out_tvalid_r && !out_tready;
  assign status.div_needed = div_needed_r;

endmodule

@@ design/contact_safety_state_machine.sv @@
// ----------------------------------------------------------------------------
// contact_safety_state_machine
// Support-state tracker for a two-wheeled body: grace-extended wheel contact,
// debounced state changes, a recovery phase and a ramped control authority.
// ----------------------------------------------------------------------------
// Usage. Each control tick is one transfer on the in_ channel; it carries the
// raw contact mask, roll, pitch and the tick length in microseconds. Every
// input transfer yields exactly one result transfer on the out_ channel with
// the new safety state, a change flag, support flags, the authority in Q1.15,
// the time spent in the state and the grace-extended contact mask.
// Sequence. The item is taken in two update steps. In recovery, before the
// ramp time is reached, a serial restoring divider then works out the ramp
// fraction one quotient bit per cycle, 14 bits in all; otherwise the divider
// does not run. The result is then loaded into the output register as soon
// as that is free, and the next item can be accepted in the cycle after the
// load.
// Stalls. The result sits in an output register, so a new tick is accepted
// while the previous result still waits; the block only holds in_tready low
// while it is busy, or while a finished result cannot be loaded because
// the output register is still full.
// Reset (rst_n, synchronous, active low) gives airborne with all timers zero,
// restores the default configuration and drops out_tvalid.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and
// are meant for times when no tick is in flight.
// ----------------------------------------------------------------------------
module contact_safety_state_machine #(
  parameter int TIME_BITS  = 24,
  parameter int ANGLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [cssm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cssm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // grounded_mask[1:0], roll_angle[17:2], pitch_angle[33:18], tick_us[49:34],
  // zero fill [55:50]
  input  logic [55:0]                     in_tdata,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // safety_state[2:0], state switch flag[3], one-wheel support flag[4],
  // airborne[5], authority[21:6], elapsed_in_state_us[45:22],
  // effective_grounded_mask[47:46]
  output logic [47:0]                     out_tdata
);
  import cssm_pkg::*;

  cssm_cmd_t    cmd;
  cssm_status_t status;

  logic [2:0]           safety_state;
  logic                 state_switched, one_wheel_support, airborne;
  logic [Q15_W-1:0]     authority;
  logic [ELAPSED_W-1:0] elapsed_in_state_us;
  logic [1:0]           effective_grounded_mask;

  cssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cssm_dp #(
    .TIME_BITS  (TIME_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_addr                (cfg_addr),
    .cfg_wdata               (cfg_wdata),
    .grounded_mask           (in_tdata[1:0]),
    .roll_angle              (in_tdata[17:2]),
    .pitch_angle             (in_tdata[33:18]),
    .tick_us                 (in_tdata[49:34]),
    .cmd                     (cmd),
    .status                  (status),
    .out_tready              (out_tready),
    .out_tvalid              (out_tvalid),
    .safety_state            (safety_state),
    .state_switched          (state_switched),
    .one_wheel_support       (one_wheel_support),
    .airborne                (airborne),
    .authority               (authority),
    .elapsed_in_state_us     (elapsed_in_state_us),
    .effective_grounded_mask (effective_grounded_mask)
  );

  // The zero fill bits of in_tdata carry nothing and are left unread.
  assign out_tdata = {effective_grounded_mask, elapsed_in_state_us, authority,
                      airborne, one_wheel_support, state_switched, safety_state};

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for contact_safety_state_machine. A short table of
// directed control ticks comes first. Several register settings follow,
// each with random tick sequences. Every accepted tick is run through a
// local support-state predictor. Every result transfer is compared field by
// field with the oldest expected report.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cssm_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  // Even the slowest tick, the one that runs the divider, settles well within
  // this time before a register write or the final verdict.
  localparam int SETTLE_CYCLES = 30;
  localparam int LONG_HOLD     = 300;
  localparam int NUM_DIRECTED  = 20;
  localparam int NUM_PHASES    = 5;
  localparam int RANDOM_TICKS  = 110;
  localparam int SATURATE_RUN  = 260;

  // No register exists at the last index, so a write there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] REG_LIST [7] = '{
    REG_GRACE_TIME, REG_LOSS_DEBOUNCE, REG_REC_DEBOUNCE, REG_REC_RAMP,
    REG_MAX_ROLL, REG_MAX_PITCH, REG_SINGLE_SCALE
  };

  // One control tick, in natural field order. It is packed into in_tdata
  // by an explicit concatenation.
  typedef struct packed {
    logic [1:0]         mask;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic [15:0]        tick_us;
  } contact_tick_t;

  // One result. The layout matches out_tdata bit for bit, MSB first.
  typedef struct packed {
    logic [1:0]    eff_mask;
    logic [23:0]   elapsed;
    logic [15:0]   authority;
    logic          air;
    logic          single;
    logic          changed;
    safety_state_t state;
  } support_report_t;

  typedef struct packed {
    logic            typed;
    contact_tick_t   tick;
    support_report_t report;
  } directed_row_t;

  // Directed ticks. They start under the reset configuration. Only the
  // first two rows carry a typed-in report. Those rows are the airborne
  // idle right after reset, and a full-length tick that starts the first
  // wheel's grace timer without a state change yet. All other rows are
  // predicted.
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{1'b1, '{2'b00, 16'sd0, 16'sd0, 16'd0},
      '{eff_mask: 2'b00, elapsed: 24'd0, authority: Q15_ZERO, air: 1'b1,
        single: 1'b0, changed: 1'b0, state: ST_AIR}},
    '{1'b1, '{2'b01, 16'h7FFF, 16'h8000, 16'd65535},
      '{eff_mask: 2'b01, elapsed: 24'd65535, authority: Q15_ZERO, air: 1'b1,
        single: 1'b0, changed: 1'b0, state: ST_AIR}},
    // The first wheel settles, then the second one.
    '{1'b0, '{2'b01, 16'sd0, 16'sd0, 16'd65535}, '0},
    '{1'b0, '{2'b10, 16'sd0, 16'sd0, 16'd10000}, '0},
    '{1'b0, '{2'b10, 16'sd0, 16'sd0, 16'd30000}, '0},
    // Dual contact requests recovery. The ramp runs through the divider.
    '{1'b0, '{2'b11, 16'h8000, 16'sd0, 16'd0}, '0},
    '{1'b0, '{2'b11, 16'sd0, 16'sd0, 16'd40000}, '0},
    '{1'b0, '{2'b11, 16'sd0, 16'sd0, 16'd40000}, '0},
    '{1'b0, '{2'b11, 16'h8000, 16'sd0, 16'd65535}, '0},
    '{1'b0, '{2'b11, 16'sd0, 16'h7FFF, 16'd65535}, '0},
    '{1'b0, '{2'b11, 16'sd1434, -16'sd1434, 16'd65535}, '0},
    '{1'b0, '{2'b11, 16'sd1434, -16'sd1434, 16'd65535}, '0},
    // The ramp time is met, but the roll is one step over its limit.
    '{1'b0, '{2'b11, 16'sd1435, 16'sd0, 16'd65535}, '0},
    // Both angles sit exactly on their limits, so recovery ends.
    '{1'b0, '{2'b11, -16'sd1434, 16'sd1434, 16'd1}, '0},
    '{1'b0, '{2'b11, 16'sd0, 16'sd0, 16'd100}, '0},
    // Lift-off. The grace timers run out, and the loss debounce follows.
    '{1'b0, '{2'b00, 16'sd0, 16'sd0, 16'd65535}, '0},
    '{1'b0, '{2'b00, 16'sd0, 16'sd0, 16'd0}, '0},
    '{1'b0, '{2'b00, 16'sd0, 16'sd0, 16'd20000}, '0},
    '{1'b0, '{2'b01, 16'h5555, 16'hAAAA, 16'd3}, '0},
    '{1'b0, '{2'b10, 16'sd0, 16'sd0, 16'd25000}, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [55:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;

  // Predictor copy of the configuration.
  logic [23:0] cfg_grace, cfg_loss_db, cfg_rec_db, cfg_ramp;
  logic [14:0] cfg_max_roll, cfg_max_pitch;
  logic [15:0] cfg_scale;

  // Predictor copy of the state.
  logic [23:0]   wheel0_hold, wheel1_hold, mode_time, pending_time;
  safety_state_t mode, pending_mode;

  support_report_t pending_reports[$];
  int unsigned     mismatches = 0;
  int unsigned     ticks_sent = 0;
  int unsigned     cycles = 0;
  bit              quiet = 1'b0;      // no idling on either side
  bit              long_hold = 1'b0;  // receiver holds off once, then the flag clears
  logic [23:0]     phase_settings [7];

  contact_safety_state_machine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  task automatic reset_tracker();
    cfg_grace     = 24'd50000;
    cfg_loss_db   = 24'd20000;
    cfg_rec_db    = 24'd50000;
    cfg_ramp      = 24'd300000;
    cfg_max_roll  = 15'd1434;
    cfg_max_pitch = 15'd1434;
    cfg_scale     = 16'd19661;
    wheel0_hold   = '0;
    wheel1_hold   = '0;
    mode_time     = '0;
    pending_time  = '0;
    mode          = ST_AIR;
    pending_mode  = ST_AIR;
  endtask

  function automatic void apply_register(logic [CFG_ADDR_W-1:0] idx, logic [23:0] val);
    case (idx)
      REG_GRACE_TIME:    cfg_grace = val;
      REG_LOSS_DEBOUNCE: cfg_loss_db = val;
      REG_REC_DEBOUNCE:  cfg_rec_db = val;
      REG_REC_RAMP:      cfg_ramp = val;
      REG_MAX_ROLL:      cfg_max_roll = val[14:0];
      REG_MAX_PITCH:     cfg_max_pitch = val[14:0];
      REG_SINGLE_SCALE:  cfg_scale = val[15:0];
      default: ;
    endcase
  endfunction

  // Timer sums stop at the all-ones value.
  function automatic logic [23:0] sat_sum(logic [23:0] a, logic [15:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  // The magnitude of the most negative angle is 32768. That is larger than
  // any limit.
  function automatic logic [16:0] angle_size(logic signed [15:0] a);
    logic signed [16:0] w;
    w = a;
    return (w < 0) ? 17'(-w) : 17'(w);
  endfunction

  function automatic support_report_t track_support(contact_tick_t t);
    safety_state_t   prior, seen, wanted;
    logic [16:0]     roll_size, pitch_size;
    logic [23:0]     debounce;
    logic [38:0]     scaled;
    support_report_t r;

    prior      = mode;
    roll_size  = angle_size(t.roll);
    pitch_size = angle_size(t.pitch);

    wheel0_hold = t.mask[0] ? cfg_grace :
                  (wheel0_hold > 24'(t.tick_us) ? wheel0_hold - 24'(t.tick_us) : '0);
    wheel1_hold = t.mask[1] ? cfg_grace :
                  (wheel1_hold > 24'(t.tick_us) ? wheel1_hold - 24'(t.tick_us) : '0);

    case (t.mask)
      2'b11:   seen = ST_DUAL;
      2'b01:   seen = ST_FIRST;
      2'b10:   seen = ST_SECOND;
      default: seen = ST_AIR;
    endcase

    mode_time = sat_sum(mode_time, t.tick_us);
    wanted = (seen == ST_DUAL && mode != ST_DUAL) ? ST_RECOVERY : seen;
    if (wanted != pending_mode) begin
      pending_mode = wanted;
      pending_time = '0;
    end else begin
      pending_time = sat_sum(pending_time, t.tick_us);
    end
    debounce = (wanted == ST_RECOVERY) ? cfg_rec_db : cfg_loss_db;
    if (wanted != mode && pending_time >= debounce) begin
      mode      = wanted;
      mode_time = '0;
    end
    if (mode == ST_RECOVERY && seen == ST_DUAL && mode_time >= cfg_ramp &&
        roll_size <= 17'(cfg_max_roll) && pitch_size <= 17'(cfg_max_pitch)) begin
      mode         = ST_DUAL;
      pending_mode = ST_DUAL;
      mode_time    = '0;
      pending_time = '0;
    end

    r.state   = mode;
    r.changed = (mode != prior);
    r.single  = (mode == ST_FIRST || mode == ST_SECOND);
    r.air     = (mode == ST_AIR);
    case (mode)
      ST_AIR:            r.authority = Q15_ZERO;
      ST_FIRST, ST_SECOND: r.authority = (cfg_scale > Q15_ONE) ? Q15_ONE : cfg_scale;
      ST_RECOVERY: begin
        if (cfg_ramp == '0 || mode_time >= cfg_ramp) begin
          r.authority = Q15_ONE;
        end else begin
          scaled = {15'd0, mode_time} << 14;
          r.authority = Q15_HALF + 16'(scaled / {15'd0, cfg_ramp});
        end
      end
      default:           r.authority = Q15_ONE;
    endcase
    r.elapsed  = mode_time;
    r.eff_mask = {wheel1_hold != '0, wheel0_hold != '0};
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  // The caller is at a falling edge. The task optionally idles, offers the
  // tick, and waits for the rising edge that makes the transfer. It then
  // queues the expected report and returns at the next falling edge with
  // in_tvalid still high.
  task automatic send_tick(contact_tick_t t, logic typed, support_report_t report);
    support_report_t predicted;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'd0, t.tick_us, t.pitch, t.roll, t.mask};
    do @(posedge clk); while (!in_tready);
    predicted = track_support(t);
    pending_reports.push_back(typed ? report : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_tick(int unsigned scale);
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'd65535;
      default: ;
    endcase
    case (scale)
      0:       return 16'($urandom_range(0, 1000));
      1:       return 16'($urandom_range(0, 20000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Calm angles stay close to the exit limits and sometimes sit at zero.
  // Wild angles take any value.
  function automatic logic [15:0] pick_angle(bit calm);
    if (!calm) return 16'($urandom);
    if ($urandom_range(0, 3) == 0) return 16'd0;
    return 16'($urandom_range(0, 5000)) - 16'd2500;
  endfunction

  task automatic send_hold(logic [1:0] mask, int unsigned len, int unsigned scale, bit calm);
    contact_tick_t t;
    repeat (len) begin
      t.mask    = mask;
      t.roll    = pick_angle(calm);
      t.pitch   = pick_angle(calm);
      t.tick_us = pick_tick(scale);
      send_tick(t, 1'b0, '0);
    end
  endtask

  // Most segments hold one contact pattern long enough to pass the
  // debounce. Many of them end in dual contact, so that the recovery ramp
  // and its exit are reached often. A share is noise, where every tick has
  // random fields.
  task automatic run_random_ticks(int unsigned count);
    int unsigned   first, kind, scale;
    bit            calm;
    contact_tick_t t;
    first = ticks_sent;
    while (ticks_sent - first < count) begin
      kind  = $urandom_range(0, 9);
      scale = $urandom_range(0, 2);
      calm  = ($urandom_range(0, 4) != 0);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) begin
          t = {2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom)};
          send_tick(t, 1'b0, '0);
        end
      end else if (kind <= 4) begin
        send_hold(2'($urandom_range(0, 2)), $urandom_range(1, 3), scale, calm);
        send_hold(2'b11, $urandom_range(4, 20), scale, calm);
      end else begin
        send_hold(2'($urandom_range(0, 3)), $urandom_range(1, 10), scale, calm);
      end
    end
  endtask

  task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [23:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_register(idx, val);
  endtask

  // The sender pauses here until every predicted report has been matched.
  task automatic wait_until_drained();
    in_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Result side
  // -------------------------------------------------------------------------

  // out_tready changes on the falling edge. It stalls in short random
  // bursts. Once per run it holds off for a long stretch while the sender
  // keeps offering ticks, so that the block fills up and drops in_tready.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Each result transfer is compared field by field with the oldest
  // expected report.
  initial begin
    support_report_t got, want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid && out_tready) begin
        got = support_report_t'(out_tdata);
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("safety_state", want.state, got.state);
          check_field("state_switched", want.changed, got.changed);
          check_field("one_wheel_support", want.single, got.single);
          check_field("airborne", want.air, got.air);
          check_field("authority", want.authority, got.authority);
          check_field("elapsed_in_state_us", want.elapsed, got.elapsed);
          check_field("effective_grounded_mask", want.eff_mask, got.eff_mask);
        end
      end
    end
  end

  // The watchdog stops a hung run.
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("RESULT: ERROR");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    contact_tick_t t;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    reset_tracker();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // The directed table runs under the reset configuration.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].report);
    end

    // Each phase rewrites every register on an idle block and then runs
    // random ticks. The phases are all zeros, all ones, a tight realistic
    // set, a random set, and a set with the shortest nonzero ramp and the
    // widest roll limit.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_until_drained();
      case (phase)
        0: phase_settings = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
        1: phase_settings = '{default: 24'hFFFFFF};
        2: phase_settings = '{24'd20000, 24'd5000, 24'd10000, 24'd40000,
                              24'd2000, 24'd2000, 24'd32768};
        3: phase_settings = '{24'($urandom_range(0, 200000)),
                              24'($urandom_range(0, 60000)),
                              24'($urandom_range(0, 60000)),
                              24'($urandom_range(1, 400000)),
                              24'($urandom_range(500, 4000)),
                              24'($urandom_range(500, 4000)),
                              24'($urandom_range(0, 65535))};
        default: phase_settings = '{24'd50000, 24'd20000, 24'd50000, 24'd1,
                                    24'd32767, 24'd1434, 24'd19661};
      endcase
      for (int r = 0; r < 7; r++) begin
        write_register(REG_LIST[r], phase_settings[r]);
      end
      // A write to the unused index must leave every register alone.
      if (phase == 1) write_register(REG_UNUSED, 24'h00A5A5);

      if (phase == 2) begin
        // The receiver holds off while a long airborne stretch of random-length
        // ticks keeps coming and runs up the state time and the debounce time;
        // full-length airborne ticks follow.
        long_hold = 1'b1;
        send_hold(2'b00, SATURATE_RUN, 2, 1'b1);
        t = '{2'b00, 16'sd0, 16'sd0, 16'd65535};
        repeat (4) send_tick(t, 1'b0, '0);
      end

      // The last phase runs with no idling on either side.
      if (phase == NUM_PHASES - 1) quiet = 1'b1;
      run_random_ticks(RANDOM_TICKS);
    end

    wait_until_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
